@@ src/sps_pkg.sv @@
// Package for the sphere point sampler: widths, kind codes, Q30 constants,
// sideband type and the rounding multiply helpers.
// No dependencies.
`timescale 1ns / 1ps

package sps_pkg;

  // Draw width and stream widths
  localparam int DRAW_BITS = 24;
  localparam int IN_RAW_W  = 127 + 3 * DRAW_BITS;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 96;

  // Sample kinds
  localparam logic [1:0] KIND_CIRCLE = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_DISK   = 2'd2;
  localparam logic [1:0] KIND_BALL   = 2'd3;

  // Q30 constants
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [63:0] HALF_Q30 = 64'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;

  // Horner divisors, innermost term first
  localparam int N_TERMS = 5;
  localparam int SIN_DIV [N_TERMS] = '{110, 72, 42, 20, 6};
  localparam int COS_DIV [N_TERMS] = '{132, 90, 56, 30, 12};

  // Pipeline depths
  localparam int SQ_STAGES = 16;   // two root bits per stage, 31 iterations
  localparam int CB_STAGES = 11;   // two cube root bits per stage, 21 iterations
  localparam int TRIG_LINE = 16;   // Horner levels inside the trig unit
  localparam int Z_DLY     = 18;   // z from stage 1 to stage 18
  localparam int VOL_DLY   = 6;    // cube root from stage 12 to stage 18
  localparam int SIDE_DLY  = 22;   // sideband stages 0..21
  localparam int VALID_DLY = 23;   // valid stages 0..22

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        rad;
  } side_t;

  // Unsigned Q30 product, rounded half up
  function automatic logic [33:0] umulq(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = ({32'b0, a} * {32'b0, b}) + HALF_Q30;
    return 34'(p >> 30);
  endfunction

  // Signed Q30 product, rounded half away from zero
  function automatic logic signed [34:0] smulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] p;
    logic [34:0] m;
    neg = a[31] ^ b[31];
    ua  = a[31] ? 32'(-a) : 32'(a);
    ub  = b[31] ? 32'(-b) : 32'(b);
    p   = ({32'b0, ua} * {32'b0, ub}) + HALF_Q30;
    m   = 35'(p >> 30);
    return neg ? -signed'(m) : signed'(m);
  endfunction

endpackage

@@ src/sps_trig.sv @@
// Pipelined sine/cosine of a 32-bit turn phase, Q30 results.
// Octant fold, Taylor Horner series with constant-reciprocal divides.
// Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_trig (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  // Octant fold and angle in radians (Q30)
  logic [2:0]  oct1_r;
  logic [29:0] x1_r;
  logic [29:0] a_fold;
  logic [63:0] ang_p;
  logic [29:0] x1_nxt;

  always_comb begin
    a_fold = phase[29] ? (30'h2000_0000 - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};
    ang_p  = ({34'b0, a_fold} * {32'b0, sps_pkg::PI_Q30}) + 64'h4000_0000;
    x1_nxt = 30'(ang_p >> 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oct1_r <= phase[31:29];
      x1_r   <= x1_nxt;
    end
  end

  // x squared and the level lines that carry x, x^2 and octant
  logic [29:0] xl_r   [sps_pkg::TRIG_LINE];
  logic [29:0] x2l_r  [sps_pkg::TRIG_LINE];
  logic [2:0]  octl_r [sps_pkg::TRIG_LINE];
  logic [33:0] x2_full;

  assign x2_full = sps_pkg::umulq({2'b0, x1_r}, {2'b0, x1_r});

  always_ff @(posedge clk) begin
    if (en) begin
      xl_r[0]   <= x1_r;
      x2l_r[0]  <= x2_full[29:0];
      octl_r[0] <= oct1_r;
      for (int l = 1; l < sps_pkg::TRIG_LINE; l++) begin
        xl_r[l]   <= xl_r[l-1];
        x2l_r[l]  <= x2l_r[l-1];
        octl_r[l] <= octl_r[l-1];
      end
    end
  end

  // Horner steps: divide (two stages), then multiply by x^2
  logic [30:0] vin_s [sps_pkg::N_TERMS];
  logic [30:0] vin_c [sps_pkg::N_TERMS];
  logic [30:0] qs_r  [sps_pkg::N_TERMS];
  logic [30:0] qc_r  [sps_pkg::N_TERMS];
  logic [30:0] vs_r  [sps_pkg::N_TERMS];
  logic [30:0] vc_r  [sps_pkg::N_TERMS];
  logic [30:0] ts_r  [sps_pkg::N_TERMS];
  logic [30:0] tc_r  [sps_pkg::N_TERMS];
  logic [30:0] ms_r  [sps_pkg::N_TERMS-1];
  logic [30:0] mc_r  [sps_pkg::N_TERMS-1];
  logic [30:0] sfin_r;
  logic [30:0] cfin_r;

  assign vin_s[0] = {1'b0, x2l_r[0]};
  assign vin_c[0] = {1'b0, x2l_r[0]};

  for (genvar i = 0; i < sps_pkg::N_TERMS; i++) begin : g_step
    localparam logic [30:0] RS = 31'((64'd1 << 31) / sps_pkg::SIN_DIV[i]);
    localparam logic [30:0] RC = 31'((64'd1 << 31) / sps_pkg::COS_DIV[i]);
    localparam logic [31:0] DS = 32'(sps_pkg::SIN_DIV[i]);
    localparam logic [31:0] DC = 32'(sps_pkg::COS_DIV[i]);

    logic [61:0] ps;
    logic [61:0] pc;
    logic [31:0] rem_s;
    logic [31:0] rem_c;
    logic [30:0] q_s;
    logic [30:0] q_c;

    // reciprocal estimate, at most one below the true quotient
    always_comb begin
      ps = {31'b0, vin_s[i]} * {31'b0, RS};
      pc = {31'b0, vin_c[i]} * {31'b0, RC};
    end

    // one-step correction of the quotient
    always_comb begin
      rem_s = {1'b0, vs_r[i]} - ({1'b0, qs_r[i]} * DS);
      rem_c = {1'b0, vc_r[i]} - ({1'b0, qc_r[i]} * DC);
      q_s   = qs_r[i] + 31'(rem_s >= DS);
      q_c   = qc_r[i] + 31'(rem_c >= DC);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qs_r[i] <= ps[61:31];
        qc_r[i] <= pc[61:31];
        vs_r[i] <= vin_s[i];
        vc_r[i] <= vin_c[i];
        ts_r[i] <= sps_pkg::ONE_Q30 - q_s;
        tc_r[i] <= sps_pkg::ONE_Q30 - q_c;
      end
    end

    if (i < sps_pkg::N_TERMS - 1) begin : g_mul
      logic [33:0] m_s;
      logic [33:0] m_c;
      assign m_s = sps_pkg::umulq({2'b0, x2l_r[3*i+2]}, {1'b0, ts_r[i]});
      assign m_c = sps_pkg::umulq({2'b0, x2l_r[3*i+2]}, {1'b0, tc_r[i]});
      always_ff @(posedge clk) begin
        if (en) begin
          ms_r[i] <= m_s[30:0];
          mc_r[i] <= m_c[30:0];
        end
      end
      assign vin_s[i+1] = ms_r[i];
      assign vin_c[i+1] = mc_r[i];
    end
  end

  // Final terms: s = x*t, c = 1 - x^2*t/2
  logic [33:0] s_full;
  logic [33:0] c_full;

  assign s_full = sps_pkg::umulq({2'b0, xl_r[14]}, {1'b0, ts_r[sps_pkg::N_TERMS-1]});
  assign c_full = sps_pkg::umulq({2'b0, x2l_r[14]}, {1'b0, tc_r[sps_pkg::N_TERMS-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      sfin_r <= s_full[30:0];
      cfin_r <= sps_pkg::ONE_Q30 - c_full[31:1];
    end
  end

  // Octant symmetry
  logic signed [31:0] cs_nxt;
  logic signed [31:0] sn_nxt;
  logic signed [31:0] sp;
  logic signed [31:0] cp;

  always_comb begin
    sp = signed'({1'b0, sfin_r});
    cp = signed'({1'b0, cfin_r});
    case (octl_r[15])
      3'd0:    begin cs_nxt = cp;  sn_nxt = sp;  end
      3'd1:    begin cs_nxt = sp;  sn_nxt = cp;  end
      3'd2:    begin cs_nxt = -sp; sn_nxt = cp;  end
      3'd3:    begin cs_nxt = -cp; sn_nxt = sp;  end
      3'd4:    begin cs_nxt = -cp; sn_nxt = -sp; end
      3'd5:    begin cs_nxt = -sp; sn_nxt = -cp; end
      3'd6:    begin cs_nxt = sp;  sn_nxt = -cp; end
      default: begin cs_nxt = cp;  sn_nxt = -sp; end
    endcase
  end

  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cs_nxt;
      sin_r <= sn_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

@@ src/sps_isqrt.sv @@
// Pipelined integer square root, floor(sqrt(n)) for n up to 2^60.
// Two restoring iterations per stage.
// Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] n_in,
  output logic [30:0] root
);

  logic [61:0] n_r   [sps_pkg::SQ_STAGES+1];
  logic [61:0] res_r [sps_pkg::SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= {1'b0, n_in};
      res_r[0] <= '0;
    end
  end

  for (genvar s = 1; s <= sps_pkg::SQ_STAGES; s++) begin : g_stage
    localparam int K0 = 2 * (s - 1);
    logic [61:0] nn;
    logic [61:0] rr;
    logic [61:0] bb;

    // iteration bit = 4^(30-k)
    always_comb begin
      nn = n_r[s-1];
      rr = res_r[s-1];
      bb = '0;
      for (int j = 0; j < 2; j++) begin
        if (K0 + j <= 30) begin
          bb = 62'(1) << (60 - 2 * (K0 + j));
          if (nn >= rr + bb) begin
            nn = nn - (rr + bb);
            rr = (rr >> 1) + bb;
          end else begin
            rr = rr >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]   <= nn;
        res_r[s] <= rr;
      end
    end
  end

  assign root = res_r[sps_pkg::SQ_STAGES][30:0];

endmodule

@@ src/sps_icbrt.sv @@
// Pipelined integer cube root, floor(cbrt(n)) for n below 2^60.
// Bit-by-bit with running square and cube, no multipliers.
// Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_icbrt (
  input  logic        clk,
  input  logic        en,
  input  logic [59:0] n_in,
  output logic [20:0] root
);

  logic [59:0] n_r  [sps_pkg::CB_STAGES+1];
  logic [20:0] y_r  [sps_pkg::CB_STAGES+1];
  logic [41:0] y2_r [sps_pkg::CB_STAGES+1];
  logic [63:0] y3_r [sps_pkg::CB_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]  <= n_in;
      y_r[0]  <= '0;
      y2_r[0] <= '0;
      y3_r[0] <= '0;
    end
  end

  for (genvar s = 1; s <= sps_pkg::CB_STAGES; s++) begin : g_stage
    localparam int B0 = 20 - 2 * (s - 1);
    logic [20:0] yy;
    logic [41:0] yy2;
    logic [63:0] yy3;
    logic [41:0] t2;
    logic [63:0] t3;

    // (y+2^b)^2 and (y+2^b)^3 from the running values
    always_comb begin
      yy  = y_r[s-1];
      yy2 = y2_r[s-1];
      yy3 = y3_r[s-1];
      t2  = '0;
      t3  = '0;
      for (int j = 0; j < 2; j++) begin
        if (B0 - j >= 0) begin
          t2 = yy2 + (42'(yy) << (B0 - j + 1)) + (42'(1) << (2 * (B0 - j)));
          t3 = yy3 + ((64'(yy2) + (64'(yy2) << 1)) << (B0 - j))
             + ((64'(yy) + (64'(yy) << 1)) << (2 * (B0 - j)))
             + (64'(1) << (3 * (B0 - j)));
          if (t3 <= 64'(n_r[s-1])) begin
            yy  = yy | (21'(1) << (B0 - j));
            yy2 = t2;
            yy3 = t3;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]  <= n_r[s-1];
        y_r[s]  <= yy;
        y2_r[s] <= yy2;
        y3_r[s] <= yy3;
      end
    end
  end

  assign root = y_r[sps_pkg::CB_STAGES];

endmodule

@@ src/sphere_point_sampler.sv @@
// Sphere point sampler: point on a circle or sphere, or inside a disk or ball.
// Takes one item per cycle while the output is not stalled.
// The whole pipeline advances together; it holds while a result waits untaken.
// Depth is set by the sin/cos Horner chain and the 31-step square root.
// Reset (rst_n, synchronous) clears only the stage valid bits.
// Depends on sps_pkg, sps_trig, sps_isqrt, sps_icbrt.
`timescale 1ns / 1ps

module sphere_point_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // centre_x, centre_y, centre_z, radius, u_draw, v_draw, w_draw, zero pad
  input  logic [sps_pkg::IN_DATA_W-1:0] in_tdata,
  // kind
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // x_out, y_out, z_out
  output logic [sps_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int D = sps_pkg::DRAW_BITS;

  // Pipeline enable
  logic en;
  logic v_r [sps_pkg::VALID_DLY];

  assign en         = !v_r[sps_pkg::VALID_DLY-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[sps_pkg::VALID_DLY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sps_pkg::VALID_DLY; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < sps_pkg::VALID_DLY; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Stage 0: input item and sideband line
  sps_pkg::side_t side_r [sps_pkg::SIDE_DLY];
  sps_pkg::side_t side_in;
  logic [D-1:0] du0_r;
  logic [D-1:0] dv0_r;
  logic [D-1:0] dw0_r;

  always_comb begin
    side_in.kind = in_tuser;
    side_in.cx   = signed'(in_tdata[31:0]);
    side_in.cy   = signed'(in_tdata[63:32]);
    side_in.cz   = signed'(in_tdata[95:64]);
    side_in.rad  = in_tdata[126:96];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      du0_r     <= in_tdata[127 +: D];
      dv0_r     <= in_tdata[127 + D +: D];
      dw0_r     <= in_tdata[127 + 2*D +: D];
      for (int i = 1; i < sps_pkg::SIDE_DLY; i++) side_r[i] <= side_r[i-1];
    end
  end

  // Draw scaling: turn phase, sphere z, radial draw in Q60
  logic [D+31:0] ph_wide;
  logic [D+30:0] zu_wide;
  logic [D+59:0] w_wide;
  logic [31:0]   phase0;
  logic signed [31:0] z0;
  logic [30:0]   az0;
  logic [59:0]   w60_0;

  always_comb begin
    ph_wide = {(side_r[0].kind[0] ? dv0_r : du0_r), 32'b0} >> D;
    phase0  = ph_wide[31:0];
    zu_wide = {du0_r, 31'b0} >> D;
    z0      = signed'({1'b0, zu_wide[30:0]}) - 32'sh4000_0000;
    az0     = z0[31] ? 31'(-z0) : 31'(z0);
    w_wide  = {dw0_r, 1'b1, 59'b0} >> D;
    w60_0   = w_wide[59:0];
  end

  // Stage 1: z squared, radial draw
  logic signed [31:0] z_r [sps_pkg::Z_DLY];
  logic [61:0] az2_full;
  logic [60:0] az2_r;
  logic [59:0] w60_r;
  logic [60:0] sq_in;

  assign az2_full = {31'b0, az0} * {31'b0, az0};

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= z0;
      az2_r  <= az2_full[60:0];
      w60_r  <= w60_0;
      for (int i = 1; i < sps_pkg::Z_DLY; i++) z_r[i] <= z_r[i-1];
    end
  end

  // Square root operand: disk radius draw or ring 1 - z^2
  assign sq_in = (side_r[1].kind == sps_pkg::KIND_DISK) ? {1'b0, w60_r}
                                                        : (61'd1 << 60) - az2_r;

  // Units
  logic signed [31:0] cs18;
  logic signed [31:0] sn18;
  logic [30:0]        root18;
  logic [20:0]        cb12;

  sps_trig u_trig (
    .clk   (clk),
    .en    (en),
    .phase (phase0),
    .cos_o (cs18),
    .sin_o (sn18)
  );

  sps_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .n_in (sq_in),
    .root (root18)
  );

  sps_icbrt u_icbrt (
    .clk  (clk),
    .en   (en),
    .n_in (w60_0),
    .root (cb12)
  );

  // Cube root delay to stage 18
  logic [30:0] vol_r [sps_pkg::VOL_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      vol_r[0] <= {cb12, 10'b0};
      for (int i = 1; i < sps_pkg::VOL_DLY; i++) vol_r[i] <= vol_r[i-1];
    end
  end

  // Stage 19: ball ring scale g = vol * ring
  logic signed [34:0] g_full;
  logic signed [31:0] g19_r;
  logic signed [31:0] cs19_r;
  logic signed [31:0] sn19_r;
  logic signed [31:0] root19_r;
  logic signed [31:0] vol19_r;
  logic signed [31:0] z19_r;

  assign g_full = sps_pkg::smulq(signed'({1'b0, vol_r[sps_pkg::VOL_DLY-1]}),
                                 signed'({1'b0, root18}));

  always_ff @(posedge clk) begin
    if (en) begin
      g19_r    <= g_full[31:0];
      cs19_r   <= cs18;
      sn19_r   <= sn18;
      root19_r <= signed'({1'b0, root18});
      vol19_r  <= signed'({1'b0, vol_r[sps_pkg::VOL_DLY-1]});
      z19_r    <= z_r[sps_pkg::Z_DLY-1];
    end
  end

  // Stage 20: unit offsets per kind
  logic signed [31:0] mag;
  logic signed [31:0] zf;
  logic signed [34:0] fx_full;
  logic signed [34:0] fy_full;
  logic signed [34:0] fz_full;
  logic signed [31:0] fx_r;
  logic signed [31:0] fy_r;
  logic signed [31:0] fz_r;
  logic               z_on;

  always_comb begin
    case (side_r[19].kind)
      sps_pkg::KIND_CIRCLE: begin
        mag = signed'({1'b0, sps_pkg::ONE_Q30});
        zf = signed'({1'b0, sps_pkg::ONE_Q30}); z_on = 1'b0;
      end
      sps_pkg::KIND_SPHERE: begin
        mag = root19_r; zf = signed'({1'b0, sps_pkg::ONE_Q30}); z_on = 1'b1;
      end
      sps_pkg::KIND_DISK: begin
        mag = root19_r; zf = signed'({1'b0, sps_pkg::ONE_Q30}); z_on = 1'b0;
      end
      default: begin
        mag = g19_r; zf = vol19_r; z_on = 1'b1;
      end
    endcase
    fx_full = sps_pkg::smulq(mag, cs19_r);
    fy_full = sps_pkg::smulq(mag, sn19_r);
    fz_full = sps_pkg::smulq(zf, z19_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r <= fx_full[31:0];
      fy_r <= fy_full[31:0];
      fz_r <= z_on ? fz_full[31:0] : 32'sd0;
    end
  end

  // Stage 21: scale by radius
  logic signed [31:0] rad20;
  logic signed [34:0] ox_r;
  logic signed [34:0] oy_r;
  logic signed [34:0] oz_r;

  assign rad20 = signed'({1'b0, side_r[20].rad});

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= sps_pkg::smulq(rad20, fx_r);
      oy_r <= sps_pkg::smulq(rad20, fy_r);
      oz_r <= sps_pkg::smulq(rad20, fz_r);
    end
  end

  // Stage 22: add centre and saturate
  function automatic logic [31:0] sat_add(input logic signed [31:0] c,
                                          input logic signed [34:0] o);
    logic signed [35:0] s;
    s = 36'(c) + 36'(o);
    if (s > 36'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -36'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  logic [sps_pkg::OUT_DATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {sat_add(side_r[21].cz, oz_r),
                      sat_add(side_r[21].cy, oy_r),
                      sat_add(side_r[21].cx, ox_r)};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule
